/* src/assert_macros.svh */
// Assertion macros shared by the checker files of the formatter.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PCF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pcf_pkg.sv */
// Shared types, character codes and helper functions of the printf formatter.
// No dependencies; imported by the core and its checker.
package pcf_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;
    localparam int ARG_IN_W  = 32;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        PM_TEXT,
        PM_PCT,
        PM_DASH,
        PM_WIDTH
    } parse_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_NORM,
        ST_PADL,
        ST_PREFIX,
        ST_DIGITS,
        ST_PADR
    } eng_state_t;

    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_MINUS,
        PRE_HEX
    } prefix_t;

    // One digit (0..15) to its lower-case ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
            return CH_ZERO + {4'd0, d};
        else
            return CH_LA + {4'd0, d} - 8'd10;
    endfunction

    // Double-dabble correction of one BCD digit before a left shift.
    function automatic logic [3:0] dabble(input logic [3:0] d);
        if (d >= 4'd5)
            return d + 4'd3;
        else
            return d;
    endfunction

endpackage

/* src/printf_conversion_formatter_core.sv */
// printf-style integer format engine: parses format characters and emits text.
// Depends on pcf_pkg (types, character codes, digit helpers).
//
// Usage:
//  - Input stream (s_axis_*): one request per format character, with its
//    argument word. tdata = {arg_value[31:0], fmt_char[7:0]}.
//  - Output stream (m_axis_*): one request per emitted character; tlast marks
//    the final character caused by one input request, tuser flags an
//    unsupported conversion letter (then tdata is zero).
//  - Literal text and the error result: output in the cycle after accept.
//    Flag and width characters: accepted with no output.
//  - Conversion d/u/x/p: bit-serial shifting of all ARG_BITS argument bits
//    through the digit register (double dabble for decimal), stripping of up
//    to NDIG-1 leading zero digits, then one character per cycle while the
//    receiver keeps taking them.
//  - Input is taken only while the engine is idle and the output register
//    is free or being drained.
//  - Reset returns to plain text mode with flags and width cleared.
//  - A stalled receiver holds the output register; emission pauses until it
//    is taken, nothing is dropped.
module printf_conversion_formatter_core
    import pcf_pkg::*;
#(
    parameter int ARG_BITS  = 32,
    parameter int MAX_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] fmt_char, [39:8] arg_value
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_char
    output logic                 m_axis_tlast,
    output logic [0:0]           m_axis_tuser    // [0] bad_spec
);

    // Widest argument seen inside the core, after zero-extending the port.
    localparam int AW      = (ARG_BITS > ARG_IN_W) ? ARG_BITS : ARG_IN_W;
    // Decimal digits of ARG_BITS bits: floor(bits * log10(2)) + 1.
    localparam int NDIG    = ((ARG_BITS * 1233) >> 12) + 1;
    localparam int NB      = NDIG * 4;
    localparam int NDW     = $clog2(NDIG + 1);
    localparam int CNTW    = $clog2(ARG_BITS);
    localparam int WB      = $clog2(MAX_WIDTH + 1);
    localparam int CW      = ((WB > NDW) ? WB : NDW) + 1;

    eng_state_t            state_reg,   state_next;
    parse_mode_t           mode_reg,    mode_next;
    logic                  zero_reg,    zero_next;
    logic                  left_reg,    left_next;
    logic [WB-1:0]         width_reg,   width_next;
    logic [WB-1:0]         pad_reg,     pad_next;
    logic [ARG_BITS-1:0]   mag_reg,     mag_next;
    logic [NB-1:0]         bcd_reg,     bcd_next;
    logic [CNTW-1:0]       cnt_reg,     cnt_next;
    logic [NDW-1:0]        ndig_reg,    ndig_next;
    prefix_t               pre_reg,     pre_next;
    logic [1:0]            pre_cnt_reg, pre_cnt_next;
    logic                  hex_reg,     hex_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            char_reg,    char_next;
    logic                  last_reg,    last_next;
    logic                  bad_reg,     bad_next;

    logic [7:0]            c;
    logic [AW-1:0]         arg_wide;
    logic [ARG_BITS-1:0]   v;
    logic [ARG_BITS-1:0]   neg_v;
    logic                  slot_free;
    logic                  s_fire;
    logic [WB+3:0]         wx;
    logic [WB+3:0]         wsum;
    logic [WB-1:0]         width_sat;
    logic [NB-1:0]         bcd_adj;
    logic [3:0]            top_digit;
    logic [CW-1:0]         blen;
    logic [CW-1:0]         wext;
    logic [WB-1:0]         pad_calc;
    logic [7:0]            pad_char;

    assign c         = s_axis_tdata[7:0];
    assign arg_wide  = AW'(s_axis_tdata[S_TDATA_W-1:8]);
    assign v         = arg_wide[ARG_BITS-1:0];
    assign neg_v     = ~v + ARG_BITS'(1);
    assign slot_free = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign s_fire    = s_axis_tvalid && s_axis_tready;

    // Width accumulation: width * 10 + digit, saturated.
    assign wx        = (WB + 4)'(width_reg);
    assign wsum      = (wx << 3) + (wx << 1) + (WB + 4)'(c[3:0]);
    assign width_sat = (wsum > (WB + 4)'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : wsum[WB-1:0];

    // Digit-wise correction; hex passes the binary through untouched.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[i*4 +: 4] = hex_reg ? bcd_reg[i*4 +: 4] : dabble(bcd_reg[i*4 +: 4]);
        end
    end

    assign top_digit = bcd_reg[NB-1 -: 4];
    assign blen      = CW'(ndig_reg) + CW'(pre_cnt_reg);
    assign wext      = CW'(width_reg);
    assign pad_calc  = (wext > blen) ? WB'(wext - blen) : '0;
    assign pad_char  = zero_reg ? CH_ZERO : CH_SPACE;

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        zero_next    = zero_reg;
        left_next    = left_reg;
        width_next   = width_reg;
        pad_next     = pad_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        ndig_next    = ndig_reg;
        pre_next     = pre_reg;
        pre_cnt_next = pre_cnt_reg;
        hex_next     = hex_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        char_next    = char_reg;
        last_next    = last_reg;
        bad_next     = bad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (mode_reg == PM_TEXT)
                    begin
                        if (c == CH_PCT)
                        begin
                            mode_next  = PM_PCT;
                            zero_next  = 1'b0;
                            left_next  = 1'b0;
                            width_next = '0;
                        end
                        else
                        begin
                            // Echo the literal.
                            m_valid_next = 1'b1;
                            char_next    = c;
                            last_next    = 1'b1;
                            bad_next     = 1'b0;
                        end
                    end
                    else if ((mode_reg == PM_PCT || mode_reg == PM_DASH) && c == CH_ZERO)
                    begin
                        zero_next = 1'b1;
                        mode_next = PM_WIDTH;
                    end
                    else if (mode_reg == PM_PCT && c == CH_DASH)
                    begin
                        left_next = 1'b1;
                        mode_next = PM_DASH;
                    end
                    else if (c inside {[CH_ZERO:CH_NINE]})
                    begin
                        width_next = width_sat;
                        mode_next  = PM_WIDTH;
                    end
                    else if (c inside {CH_LD, CH_LU, CH_LX, CH_LP})
                    begin
                        // Start a conversion: load the magnitude, clear the digits.
                        mode_next = PM_TEXT;
                        hex_next  = (c == CH_LX) || (c == CH_LP);
                        bcd_next  = '0;
                        cnt_next  = CNTW'(ARG_BITS - 1);
                        state_next = ST_SHIFT;
                        if (c == CH_LD && v[ARG_BITS-1])
                        begin
                            mag_next     = neg_v;
                            pre_next     = PRE_MINUS;
                            pre_cnt_next = 2'd1;
                        end
                        else if (c == CH_LP)
                        begin
                            mag_next     = v;
                            pre_next     = PRE_HEX;
                            pre_cnt_next = 2'd2;
                        end
                        else
                        begin
                            mag_next     = v;
                            pre_next     = PRE_NONE;
                            pre_cnt_next = 2'd0;
                        end
                    end
                    else
                    begin
                        // Unknown conversion: one error result, drop the spec.
                        m_valid_next = 1'b1;
                        char_next    = CH_NUL;
                        last_next    = 1'b1;
                        bad_next     = 1'b1;
                        mode_next    = PM_TEXT;
                        zero_next    = 1'b0;
                        left_next    = 1'b0;
                        width_next   = '0;
                    end
                end
            end

            ST_SHIFT:
            begin
                // One argument bit per cycle into the digit register.
                bcd_next = {bcd_adj[NB-2:0], mag_reg[ARG_BITS-1]};
                mag_next = mag_reg << 1;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == '0)
                begin
                    ndig_next  = NDW'(NDIG);
                    state_next = ST_NORM;
                end
            end

            ST_NORM:
            begin
                // Strip leading zero digits, keeping at least one.
                if (top_digit == 4'd0 && ndig_reg > NDW'(1))
                begin
                    bcd_next  = bcd_reg << 4;
                    ndig_next = ndig_reg - NDW'(1);
                end
                else
                begin
                    pad_next = pad_calc;
                    if (!left_reg && pad_calc != '0)
                        state_next = ST_PADL;
                    else if (pre_cnt_reg != 2'd0)
                        state_next = ST_PREFIX;
                    else
                        state_next = ST_DIGITS;
                end
            end

            ST_PADL:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    char_next    = pad_char;
                    last_next    = 1'b0;
                    bad_next     = 1'b0;
                    pad_next     = pad_reg - WB'(1);
                    if (pad_reg == WB'(1))
                        state_next = (pre_cnt_reg != 2'd0) ? ST_PREFIX : ST_DIGITS;
                end
            end

            ST_PREFIX:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    last_next    = 1'b0;
                    bad_next     = 1'b0;
                    if (pre_reg == PRE_MINUS)
                        char_next = CH_DASH;
                    else if (pre_cnt_reg == 2'd2)
                        char_next = CH_ZERO;
                    else
                        char_next = CH_LX;
                    pre_cnt_next = pre_cnt_reg - 2'd1;
                    if (pre_cnt_reg == 2'd1)
                        state_next = ST_DIGITS;
                end
            end

            ST_DIGITS:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    char_next    = digit_char(top_digit);
                    bad_next     = 1'b0;
                    last_next    = (ndig_reg == NDW'(1)) && !(left_reg && pad_reg != '0);
                    bcd_next     = bcd_reg << 4;
                    ndig_next    = ndig_reg - NDW'(1);
                    if (ndig_reg == NDW'(1))
                    begin
                        if (left_reg && pad_reg != '0)
                            state_next = ST_PADR;
                        else
                        begin
                            state_next = ST_IDLE;
                            zero_next  = 1'b0;
                            left_next  = 1'b0;
                            width_next = '0;
                        end
                    end
                end
            end

            ST_PADR:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    char_next    = pad_char;
                    bad_next     = 1'b0;
                    last_next    = (pad_reg == WB'(1));
                    pad_next     = pad_reg - WB'(1);
                    if (pad_reg == WB'(1))
                    begin
                        state_next = ST_IDLE;
                        zero_next  = 1'b0;
                        left_next  = 1'b0;
                        width_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= PM_TEXT;
            zero_reg    <= 1'b0;
            left_reg    <= 1'b0;
            width_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            zero_reg    <= zero_next;
            left_reg    <= left_next;
            width_reg   <= width_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        pad_reg     <= pad_next;
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        cnt_reg     <= cnt_next;
        ndig_reg    <= ndig_next;
        pre_reg     <= pre_next;
        pre_cnt_reg <= pre_cnt_next;
        hex_reg     <= hex_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        bad_reg     <= bad_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = bad_reg;

endmodule

/* src/pcf_checker.sv */
// Port-level checker for the printf formatter core, bound to the core module.
// Depends on pcf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcf_checker
    import pcf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic [0:0]           m_axis_tuser
);

    // Hold a stalled result.
    `PCF_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output request dropped while stalled")
    `PCF_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output changed")

    // An error result is a lone NUL closing its request.
    `PCF_ASSERT(a_bad_form, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && m_axis_tdata == '0, "error result malformed")

    // No input request taken while a result is stuck in the output register.
    `PCF_ASSERT(a_no_take_full, s_axis_tvalid && s_axis_tready, !(m_axis_tvalid && !m_axis_tready), "input taken with output blocked")

endmodule

bind printf_conversion_formatter_core pcf_checker u_pcf_checker (.*);
